### rtl/core/cmi_pkg.sv
// Shared types, constants and saturating helpers for the cofactor matrix inverse.
`timescale 1ns / 1ps
package cmi_pkg;

  typedef logic [63:0] word_t;

  localparam word_t Q_ONE   = 64'h0000_0000_0001_0000;
  localparam word_t POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam word_t NEG_MIN = 64'h8000_0000_0000_0000;
  localparam int    RECIP_MSB = 48;

  function automatic word_t mag64(input word_t v);
    return v[63] ? (word_t'(0) - v) : v;
  endfunction

  function automatic word_t sat_neg(input word_t a, output logic ov);
    ov = (a == NEG_MIN);
    return ov ? POS_MAX : (word_t'(0) - a);
  endfunction

  function automatic word_t sat_add(input word_t a, input word_t b, output logic ov);
    word_t s;
    s  = a + b;
    ov = (a[63] == b[63]) && (s[63] != a[63]);
    return ov ? (a[63] ? NEG_MIN : POS_MAX) : s;
  endfunction

endpackage

### rtl/core/cofactor_matrix_inverse.sv
// Top level: matrix inverse by cofactor expansion on one shared multiplier.
// Flow: n*n elements are loaded, then a depth-first expansion (read, multiply and
// accumulate at each node) gives the determinant and a restoring divide its reciprocal;
// each result then takes its cofactor expansion, a multiply and a clip step.
// Throughput: one matrix at a time; the load port closes until the last result is taken.
// Reset: order 4, load counter cleared, no RAM clear.
`timescale 1ns / 1ps
module cofactor_matrix_inverse
  import cmi_pkg::*;
#(
  parameter int MAX_ORDER = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        matrix_order_valid,
  output logic        matrix_order_ready,
  input  logic [2:0]  matrix_order,
  input  logic        element_valid,
  output logic        element_ready,
  input  logic [31:0] element_value,
  output logic        inverse_valid,
  input  logic        inverse_ready,
  output logic [31:0] inverse_value,
  output logic        last_of_matrix,
  output logic        singular,
  output logic        saturated
);

  localparam int LW    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int NW    = $clog2(MAX_ORDER + 1);
  localparam int CELLS = MAX_ORDER * MAX_ORDER;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CW    = $clog2(CELLS + 1);

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_PICK  = 4'd2;
  localparam logic [3:0] S_ISSUE = 4'd3;
  localparam logic [3:0] S_DATA  = 4'd4;
  localparam logic [3:0] S_RET   = 4'd5;
  localparam logic [3:0] S_MUL   = 4'd6;
  localparam logic [3:0] S_MFIN  = 4'd7;
  localparam logic [3:0] S_ACC   = 4'd8;
  localparam logic [3:0] S_EDONE = 4'd9;
  localparam logic [3:0] S_DIV   = 4'd10;
  localparam logic [3:0] S_CLIP  = 4'd11;
  localparam logic [3:0] S_ZERO  = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  logic [3:0]    state;
  logic [2:0]    ord;
  logic [CW-1:0] load_count;
  logic          is_cof;
  logic          fin;
  logic [NW-1:0] sz;
  logic [LW-1:0] lvl;
  logic [LW-1:0] out_r;
  logic [LW-1:0] out_c;
  logic [MAX_ORDER-1:0] mask;
  logic [MAX_ORDER-1:0] started;
  logic [MAX_ORDER-1:0] par;
  logic [LW-1:0] colsel [MAX_ORDER];
  word_t         acc    [MAX_ORDER];
  logic [31:0]   elem   [MAX_ORDER];
  word_t         ret;
  logic          sat;
  logic          det_sat;
  logic          det_neg;
  word_t         recip;
  logic [AW-1:0] raddr;
  logic [31:0]   rdata;

  word_t          mua, mub, mres;
  logic           mneg, msh32;
  logic [127:0]   prod;
  logic [1:0]     mstep;

  word_t          drem, dd;
  logic [RECIP_MSB:0] dq;
  logic [5:0]     dcnt;

  logic [NW-1:0] n_eff;
  logic [CW-1:0] cells;
  logic          found;
  logic [LW-1:0] pick;
  logic [LW-1:0] row;
  logic          leaf;
  logic [LW-1:0] lvl_inc, lvl_dec;
  logic          cfg_hit, elem_hit;

  always_comb begin
    if (ord == 3'd0) begin
      n_eff = NW'(1);
    end else if (int'(ord) > MAX_ORDER) begin
      n_eff = NW'(MAX_ORDER);
    end else begin
      n_eff = NW'(ord);
    end
    cells = CW'(n_eff) * CW'(n_eff);
  end

  always_comb begin
    found = 1'b0;
    pick  = '0;
    for (int j = MAX_ORDER - 1; j >= 0; j--) begin
      if (!mask[j] && (!started[lvl] || LW'(j) > colsel[lvl])) begin
        found = 1'b1;
        pick  = LW'(j);
      end
    end
  end

  assign lvl_inc  = lvl + LW'(1);
  assign lvl_dec  = lvl - LW'(1);
  assign row      = (is_cof && lvl >= out_c) ? lvl_inc : lvl;
  assign leaf     = (NW'(lvl) == sz - NW'(1));
  assign matrix_order_ready = (state == S_LOAD);
  assign element_ready = (state == S_LOAD) && !matrix_order_valid;
  assign cfg_hit  = matrix_order_valid && matrix_order_ready;
  assign elem_hit = element_valid && element_ready;

  cmi_ram #(.WIDTH(32), .DEPTH(CELLS)) u_store (
    .clk   (clk),
    .we    (elem_hit),
    .waddr (load_count[AW-1:0]),
    .wdata (element_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  // shared multiplier datapath
  logic [31:0]  a_part, b_part;
  logic [63:0]  pp;
  logic [1:0]   pp_sh;
  logic [127:0] prod_sh;
  logic [63:0]  rhi, rlo, lim, rsat;
  logic         mov;
  word_t        mul_out;

  always_comb begin
    a_part  = mstep[1] ? mua[63:32] : mua[31:0];
    b_part  = mstep[0] ? mub[63:32] : mub[31:0];
    pp      = 64'(a_part) * 64'(b_part);
    pp_sh   = {1'b0, mstep[1]} + {1'b0, mstep[0]};
    prod_sh = msh32 ? (prod >> 32) : (prod >> 16);
    rhi     = prod_sh[127:64];
    rlo     = prod_sh[63:0];
    lim     = mneg ? NEG_MIN : POS_MAX;
    mov     = (rhi != 64'd0) || (rlo > lim);
    rsat    = mov ? lim : rlo;
    mul_out = mneg ? (word_t'(0) - rsat) : rsat;
  end

  // accumulate, cofactor sign and divider step
  word_t        t_neg, t_sel, acc_sum, cof_neg, cof_sel, cof_mag, q_neg;
  logic         ov_tn, ov_add, ov_cn;
  logic [64:0]  rem_s;
  logic         ge;
  logic [RECIP_MSB:0] q_new;
  logic         clip_hi, clip_lo;

  always_comb begin
    t_neg   = sat_neg(mres, ov_tn);
    t_sel   = par[lvl] ? t_neg : mres;
    acc_sum = sat_add(acc[lvl], t_sel, ov_add);
    cof_neg = sat_neg(ret, ov_cn);
    cof_sel = (out_r[0] ^ out_c[0]) ? cof_neg : ret;
    cof_mag = mag64(cof_sel);
    rem_s   = {drem, (dcnt == 6'(RECIP_MSB))};
    ge      = rem_s >= {1'b0, dd};
    q_new   = {dq[RECIP_MSB-1:0], ge};
    q_neg   = word_t'(0) - word_t'(q_new);
    clip_hi = !mres[63] && (mres[62:31] != 32'd0);
    clip_lo = mres[63] && (mres[62:31] != 32'hFFFF_FFFF);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      ord           <= 3'd4;
      load_count    <= '0;
      inverse_valid <= 1'b0;
      recip         <= '0;
      is_cof        <= 1'b0;
      fin           <= 1'b0;
      singular      <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (cfg_hit) begin
            ord        <= matrix_order;
            load_count <= '0;
          end else if (elem_hit) begin
            if (load_count + CW'(1) >= cells) begin
              load_count <= '0;
              is_cof     <= 1'b0;
              fin        <= 1'b0;
              state      <= S_START;
            end else begin
              load_count <= load_count + CW'(1);
            end
          end
        end
        S_START: begin
          for (int j = 0; j < MAX_ORDER; j++) begin
            mask[j] <= (j >= int'(n_eff)) || (is_cof && LW'(j) == out_r);
          end
          sat     <= is_cof ? det_sat : 1'b0;
          sz      <= is_cof ? n_eff - NW'(1) : n_eff;
          lvl     <= '0;
          acc[0]  <= '0;
          started <= '0;
          par     <= '0;
          if (is_cof && n_eff == NW'(1)) begin
            ret   <= Q_ONE;
            state <= S_EDONE;
          end else begin
            state <= S_PICK;
          end
        end
        S_PICK: begin
          if (found) begin
            colsel[lvl] <= pick;
            raddr <= AW'(int'(row) * int'(n_eff) + int'(pick));
            if (!leaf) begin
              started[lvl] <= 1'b1;
              mask[pick]   <= 1'b1;
            end
            state <= S_ISSUE;
          end else begin
            ret   <= acc[lvl];
            state <= S_RET;
          end
        end
        S_ISSUE: state <= S_DATA;
        S_DATA: begin
          if (leaf) begin
            ret   <= {{32{rdata[31]}}, rdata};
            state <= S_RET;
          end else begin
            elem[lvl]        <= rdata;
            lvl              <= lvl_inc;
            acc[lvl_inc]     <= '0;
            started[lvl_inc] <= 1'b0;
            par[lvl_inc]     <= 1'b0;
            state            <= S_PICK;
          end
        end
        S_RET: begin
          if (lvl == '0) begin
            state <= S_EDONE;
          end else begin
            lvl   <= lvl_dec;
            mua   <= mag64({{32{elem[lvl_dec][31]}}, elem[lvl_dec]});
            mub   <= mag64(ret);
            mneg  <= elem[lvl_dec][31] ^ ret[63];
            msh32 <= 1'b0;
            prod  <= '0;
            mstep <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= prod + ({64'd0, pp} << {pp_sh, 5'd0});
          mstep <= mstep + 2'd1;
          if (mstep == 2'd3) begin
            state <= S_MFIN;
          end
        end
        S_MFIN: begin
          mres  <= mul_out;
          sat   <= sat | mov;
          state <= fin ? S_CLIP : S_ACC;
        end
        S_ACC: begin
          acc[lvl]         <= acc_sum;
          sat              <= sat | (par[lvl] & ov_tn) | ov_add;
          par[lvl]         <= ~par[lvl];
          mask[colsel[lvl]] <= 1'b0;
          state            <= S_PICK;
        end
        S_EDONE: begin
          if (!is_cof) begin
            det_sat <= sat;
            det_neg <= ret[63];
            out_r   <= '0;
            out_c   <= '0;
            if (ret == '0) begin
              recip    <= '0;
              singular <= 1'b1;
              state    <= S_ZERO;
            end else begin
              singular <= 1'b0;
              drem     <= '0;
              dq       <= '0;
              dd       <= mag64(ret);
              dcnt     <= 6'(RECIP_MSB);
              state    <= S_DIV;
            end
          end else begin
            sat   <= sat | ((out_r[0] ^ out_c[0]) & ov_cn);
            mua   <= cof_mag;
            mub   <= mag64(recip);
            mneg  <= cof_sel[63] ^ recip[63];
            msh32 <= 1'b1;
            prod  <= '0;
            mstep <= '0;
            fin   <= 1'b1;
            state <= S_MUL;
          end
        end
        S_DIV: begin
          drem <= ge ? rem_s[63:0] - dd : rem_s[63:0];
          dq   <= q_new;
          dcnt <= dcnt - 6'd1;
          if (dcnt == 6'd0) begin
            recip  <= det_neg ? q_neg : word_t'(q_new);
            is_cof <= 1'b1;
            state  <= S_START;
          end
        end
        S_CLIP: begin
          inverse_value  <= clip_hi ? 32'h7FFF_FFFF : clip_lo ? 32'h8000_0000 : mres[31:0];
          saturated      <= sat | clip_hi | clip_lo;
          last_of_matrix <= (NW'(out_r) == n_eff - NW'(1)) && (NW'(out_c) == n_eff - NW'(1));
          inverse_valid  <= 1'b1;
          state          <= S_OUT;
        end
        S_ZERO: begin
          inverse_value  <= '0;
          saturated      <= 1'b0;
          last_of_matrix <= (NW'(out_r) == n_eff - NW'(1)) && (NW'(out_c) == n_eff - NW'(1));
          inverse_valid  <= 1'b1;
          state          <= S_OUT;
        end
        S_OUT: begin
          if (inverse_ready) begin
            inverse_valid <= 1'b0;
            fin           <= 1'b0;
            if (last_of_matrix) begin
              state <= S_LOAD;
            end else begin
              if (NW'(out_c) == n_eff - NW'(1)) begin
                out_c <= '0;
                out_r <= out_r + LW'(1);
              end else begin
                out_c <= out_c + LW'(1);
              end
              state <= singular ? S_ZERO : S_START;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    inverse_valid |-> !element_ready)
    else $error("load open while a result is pending");

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    inverse_valid && singular |-> inverse_value == 32'd0 && !saturated)
    else $error("singular result not zero");

  a_back_to_load: assert property (@(posedge clk) disable iff (rst)
    inverse_valid && inverse_ready && last_of_matrix |=> matrix_order_ready)
    else $error("no return to load after last item");
`endif

endmodule

### rtl/core/cmi_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module cmi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
